// File: rtl/core/bld_pkg.sv
// Shared constants and types for the battery level change detector.
package bld_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int WIN_LOG2     = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_BITS   = SAMPLE_BITS + WIN_LOG2;
    localparam int THR_BITS     = 12;
    localparam int CMP_BITS     = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    localparam logic [ADDR_BITS-3:0] REG_CHANGE_THRESHOLD = '0;
    localparam logic [THR_BITS-1:0]  THR_RESET = THR_BITS'(25);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;
    typedef logic [THR_BITS-1:0]    thr_t;

    typedef struct packed {
        logic    valid;
        sample_t level;
    } win_out_t;

endpackage

// File: rtl/core/bld_cell.sv
// One window cell: holds a sample and passes it on to its neighbour on each item.
module bld_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  bld_pkg::sample_t d_in,
    output bld_pkg::sample_t q_out
);

    bld_pkg::sample_t sample_reg;
    bld_pkg::sample_t sample_next;

    assign sample_next = shift_en ? d_in : sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign q_out = sample_reg;

endmodule

// File: rtl/core/bld_window.sv
// Sample window: chain of cells, running total and the floor-mean stage register.
module bld_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  bld_pkg::sample_t  in_sample,
    output logic              in_ready,
    input  logic              out_ready,
    output bld_pkg::win_out_t win_out
);

    bld_pkg::sample_t taps [0:bld_pkg::WINDOW_DEPTH];
    logic             accept;
    bld_pkg::total_t  total_reg;
    bld_pkg::total_t  total_next;
    bld_pkg::sample_t level_reg;
    bld_pkg::sample_t level_next;
    logic             valid_reg;
    logic             valid_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign taps[0]  = in_sample;

    for (genvar i = 0; i < bld_pkg::WINDOW_DEPTH; i++) begin : g_cell
        bld_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .d_in     (taps[i]),
            .q_out    (taps[i+1])
        );
    end

    // oldest entry leaves the window as the new one enters
    always_comb begin
        total_next = total_reg;
        level_next = level_reg;
        if (accept) begin
            total_next = total_reg - bld_pkg::TOTAL_BITS'(taps[bld_pkg::WINDOW_DEPTH])
                         + bld_pkg::TOTAL_BITS'(in_sample);
            level_next = total_next[bld_pkg::TOTAL_BITS-1:bld_pkg::WIN_LOG2];
        end
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg <= level_next;
    end

    assign win_out.valid = valid_reg;
    assign win_out.level = level_reg;

endmodule

// File: rtl/core/bld_report.sv
// Deadband stage: compares the mean with the last reported level, holds the result item.
module bld_report (
    input  logic              aclk,
    input  logic              aresetn,
    input  bld_pkg::win_out_t win_in,
    output logic              in_ready,
    input  bld_pkg::thr_t     threshold,
    output logic              m_valid,
    input  logic              m_ready,
    output bld_pkg::sample_t  m_smoothed_level,
    output logic              m_report
);

    logic             take;
    bld_pkg::sample_t diff;
    logic             report_now;
    bld_pkg::sample_t last_reg;
    bld_pkg::sample_t last_next;
    logic             valid_reg;
    logic             valid_next;
    bld_pkg::sample_t level_reg;
    bld_pkg::sample_t level_next;
    logic             report_reg;
    logic             report_next;

    assign in_ready = !valid_reg || m_ready;
    assign take     = win_in.valid && in_ready;

    always_comb begin
        diff = (win_in.level > last_reg) ? (win_in.level - last_reg)
                                         : (last_reg - win_in.level);
        report_now = bld_pkg::CMP_BITS'(diff) > bld_pkg::CMP_BITS'(threshold);

        last_next   = last_reg;
        level_next  = level_reg;
        report_next = report_reg;
        if (take) begin
            level_next  = win_in.level;
            report_next = report_now;
            if (report_now) begin
                last_next = win_in.level;
            end
        end

        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        report_reg <= report_next;
    end

    assign m_valid          = valid_reg;
    assign m_smoothed_level = level_reg;
    assign m_report         = report_reg;

endmodule

// File: rtl/core/battery_level_change_detector_core.sv
// Top level of the battery level change detector: register port and item pipeline.
//
// Input channel s_*: one raw ADC sample per item (s_sample). Result channel m_*:
// one item per sample, carrying the floor mean of the last sixteen samples
// (m_smoothed_level) and a flag (m_report) that is set when that mean moved by
// more than change_threshold since the last report.
// change_threshold sits at byte address 0 of the APB port (reset 25); pready is
// always high and a write lands on the access cycle. Write it only while idle.
// A sample accepted on s_* passes two register stages, the window total and then the
// deadband compare, before its result appears on m_*.
// Throughput: one item per cycle while m_ready is high; the window is a chain of sixteen
// cells that shift on every accepted item, and the running total takes one add/subtract.
// Reset (aresetn low, synchronous) clears the window cells, the total, the last
// reported level and both stage valid bits, and restores the threshold.
// When m_ready is low the result is held; s_ready falls as soon as the window
// stage also holds an item, and rises in the cycle m_ready returns.
module battery_level_change_detector_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bld_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bld_pkg::DATA_BITS-1:0] pwdata,
    output logic [bld_pkg::DATA_BITS-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bld_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bld_pkg::SAMPLE_BITS-1:0] m_smoothed_level,
    output logic                         m_report
);

    bld_pkg::thr_t     thr_reg;
    bld_pkg::thr_t     thr_next;
    logic              wr_thr;
    logic              sel_thr;
    bld_pkg::win_out_t win_out;
    logic              win_ready;

    assign pready  = 1'b1;
    assign sel_thr = paddr[bld_pkg::ADDR_BITS-1:2] == bld_pkg::REG_CHANGE_THRESHOLD;
    assign wr_thr  = psel && penable && pwrite && pready && sel_thr;
    assign thr_next = wr_thr ? pwdata[bld_pkg::THR_BITS-1:0] : thr_reg;
    assign prdata  = sel_thr ? bld_pkg::DATA_BITS'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bld_pkg::THR_RESET;
        end else begin
            thr_reg <= thr_next;
        end
    end

    bld_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_sample (s_sample),
        .in_ready  (s_ready),
        .out_ready (win_ready),
        .win_out   (win_out)
    );

    bld_report u_report (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .win_in           (win_out),
        .in_ready         (win_ready),
        .threshold        (thr_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_smoothed_level (m_smoothed_level),
        .m_report         (m_report)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the battery level change detector: window mean and deadband report.
module tb;

    typedef struct packed {
        bld_pkg::sample_t level;
        logic             report;
    } level_report_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bld_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [bld_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [bld_pkg::DATA_BITS-1:0] prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    bld_pkg::sample_t              s_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    bld_pkg::sample_t              m_smoothed_level;
    logic                          m_report;

    localparam logic [bld_pkg::ADDR_BITS-1:0] THRESHOLD_ADDR =
        {bld_pkg::REG_CHANGE_THRESHOLD, 2'b00};

    bld_pkg::sample_t    pending_samples[$];
    level_report_t       expected_levels[$];
    logic                sample_taken = 1'b0;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         mismatch_count = 0;
    int                  walk_level = 2048;

    // Predictor state
    bld_pkg::sample_t             win_ring[bld_pkg::WINDOW_DEPTH];
    logic [bld_pkg::WIN_LOG2-1:0] win_slot = '0;
    bld_pkg::total_t              win_total = '0;
    bld_pkg::sample_t             last_reported = '0;
    bld_pkg::thr_t                cur_threshold = bld_pkg::THR_RESET;

    battery_level_change_detector_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_smoothed_level(m_smoothed_level), .m_report(m_report)
    );

    always #5 aclk = ~aclk;

    function automatic level_report_t advance_window(bld_pkg::sample_t smp);
        level_report_t    r;
        bld_pkg::sample_t lvl;
        bld_pkg::sample_t gap;
        win_total = win_total - bld_pkg::total_t'(win_ring[win_slot])
                    + bld_pkg::total_t'(smp);
        win_ring[win_slot] = smp;
        win_slot = win_slot + 1'b1;
        lvl = bld_pkg::sample_t'(win_total >> bld_pkg::WIN_LOG2);
        gap = (lvl > last_reported) ? lvl - last_reported : last_reported - lvl;
        r.report = (bld_pkg::CMP_BITS'(gap) > bld_pkg::CMP_BITS'(cur_threshold));
        if (r.report)
            last_reported = lvl;
        r.level = lvl;
        return r;
    endfunction

    // Sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sample_taken) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid  <= 1'b1;
                s_sample <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor and checker
    always @(posedge aclk) begin
        level_report_t want;
        if (!aresetn) begin
            sample_taken <= 1'b0;
        end else begin
            sample_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                expected_levels.push_back(advance_window(s_sample));
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    $display("%0t: unexpected item level %0d report %0b",
                             $time, m_smoothed_level, m_report);
                    mismatch_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_smoothed_level !== want.level) begin
                        $display("%0t: smoothed_level expected %0d actual %0d",
                                 $time, want.level, m_smoothed_level);
                        mismatch_count++;
                    end
                    if (m_report !== want.report) begin
                        $display("%0t: report expected %0b actual %0b",
                                 $time, want.report, m_report);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_valid || expected_levels.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [bld_pkg::DATA_BITS-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_threshold = bld_pkg::thr_t'(value);
    endtask

    task automatic queue_random_samples(int unsigned count);
        int unsigned mode;
        for (int unsigned i = 0; i < count; i++) begin
            mode = $urandom_range(99);
            if (mode < 45) begin
                walk_level += int'($urandom_range(60)) - 30;
            end else if (mode < 55) begin
                walk_level += int'($urandom_range(600)) - 300;
            end else if (mode < 65) begin
                walk_level = int'($urandom_range(4095));
            end
            if (walk_level < 0) walk_level = 0;
            if (walk_level > 4095) walk_level = 4095;
            if (mode < 65)
                pending_samples.push_back(bld_pkg::sample_t'(walk_level));
            else if (mode < 88)
                pending_samples.push_back(bld_pkg::sample_t'($urandom_range(4095)));
            else
                pending_samples.push_back($urandom_range(1) ? bld_pkg::sample_t'(4095)
                                                            : bld_pkg::sample_t'(0));
        end
    endtask

    task automatic run_phase(logic [bld_pkg::DATA_BITS-1:0] thr_word, int unsigned send_pct,
                             int unsigned recv_pct, int unsigned count);
        wait_drained();
        write_threshold(thr_word);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random_samples(count);
    endtask

    initial begin
        bld_pkg::sample_t directed[$];
        foreach (win_ring[i]) win_ring[i] = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Equal difference at reset threshold, then a clear move, then fill and wrap the window
        directed = '{12'd400, 12'd416, 12'd0};
        repeat (16) directed.push_back(12'hFFF);
        directed.push_back(12'hAAA);
        directed.push_back(12'h555);
        directed.push_back(12'h000);
        directed.push_back(12'h001);
        send_idle_pct = 18;
        recv_idle_pct = 71;
        foreach (directed[i]) pending_samples.push_back(directed[i]);

        run_phase(32'd0, 18, 71, 400);
        run_phase(32'hFFFF_FFFF, 18, 71, 200);
        run_phase($urandom(), 71, 18, 400);
        run_phase(32'd1, 71, 18, 200);
        run_phase({20'($urandom()), 12'd25}, 0, 0, 300);
        run_phase(32'h0000_0040, 0, 0, 100);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
